### rtl/core/lbwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbwm_pkg
// shared constants and types of the lru block window manager
// ----------------------------------------------------------------------------
package lbwm_pkg;

  localparam int SLOTS        = 8;
  localparam int WINDOW_BYTES = 32768;
  localparam int BLOCK_BYTES  = WINDOW_BYTES / SLOTS;
  localparam int BLOCK_SHIFT  = $clog2(BLOCK_BYTES);
  localparam int SLOT_W       = $clog2(SLOTS);

  // fixed field widths
  localparam int BLK_W        = 32;
  localparam int SIZE_W       = 32;
  localparam int SLOT_IDX_W   = 3;
  localparam int FILL_W       = 13;
  localparam int COUNT_W      = SIZE_W + 1;

  localparam logic [SIZE_W-1:0] SRC_SIZE_RESET = 32'd32769;

  typedef enum logic [1:0] {
    STATUS_HIT   = 2'd0,
    STATUS_MISS  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  // tag lookup result
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [BLK_W-1:0]  evicted;
  } lookup_t;

  // range check and fill window
  typedef struct packed {
    logic              in_range;
    logic [BLK_W-1:0]  offset;
    logic [FILL_W-1:0] bytes;
  } fill_t;

endpackage

### rtl/core/lbwm_tag_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbwm_tag_store
// slot tags and recency ranks, parallel lookup and lru update
// ----------------------------------------------------------------------------
module lbwm_tag_store import lbwm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [BLK_W-1:0] lookup_tag,
  input  logic             update_en,
  output lookup_t          lookup
);

  logic [BLK_W-1:0]  tags  [SLOTS];
  logic [SLOT_W-1:0] ranks [SLOTS];

  logic              hit;
  logic [SLOT_W-1:0] hit_slot;
  logic [SLOT_W-1:0] victim_slot;
  logic              victim_found;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] limit;

  always_comb begin
    hit          = 1'b0;
    hit_slot     = '0;
    victim_found = 1'b0;
    victim_slot  = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!hit && tags[i] == lookup_tag) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(i);
      end
      if (!victim_found && ranks[i] == SLOT_W'(SLOTS - 1)) begin
        victim_found = 1'b1;
        victim_slot  = SLOT_W'(i);
      end
    end
    slot  = hit ? hit_slot : victim_slot;
    limit = hit ? ranks[hit_slot] : SLOT_W'(SLOTS - 1);
  end

  assign lookup.hit     = hit;
  assign lookup.slot    = slot;
  assign lookup.evicted = tags[victim_slot];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        tags[i]  <= BLK_W'(i);
        ranks[i] <= SLOT_W'(i);
      end
    end else if (update_en) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (SLOT_W'(i) == slot) begin
          ranks[i] <= '0;
        end else if (ranks[i] < limit) begin
          ranks[i] <= ranks[i] + 1'b1;
        end
      end
      if (!hit) begin
        tags[slot] <= lookup_tag;
      end
    end
  end

endmodule

### rtl/core/lbwm_fill_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbwm_fill_calc
// block range check, fill offset and short last block size
// ----------------------------------------------------------------------------
module lbwm_fill_calc import lbwm_pkg::*; (
  input  logic [SIZE_W-1:0] src_size,
  input  logic [BLK_W-1:0]  blk_index,
  output fill_t             fill
);

  logic [COUNT_W-1:0]     total_blocks;
  logic [BLOCK_SHIFT-1:0] rem;
  logic                   short_last;

  always_comb begin
    total_blocks = (COUNT_W'(src_size) + COUNT_W'(BLOCK_BYTES - 1)) >> BLOCK_SHIFT;
    rem          = src_size[BLOCK_SHIFT-1:0];
    // last block is short only when the size is not a whole number of blocks
    short_last   = (rem != '0) &&
                   (COUNT_W'(blk_index) == COUNT_W'(src_size >> BLOCK_SHIFT));

    fill.in_range = COUNT_W'(blk_index) < total_blocks;
    fill.offset   = blk_index << BLOCK_SHIFT;
    fill.bytes    = short_last ? FILL_W'(rem) : FILL_W'(BLOCK_BYTES);
  end

endmodule

### rtl/core/lru_block_window_manager_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_block_window_manager_core
// fully associative lru tag manager for a window of file blocks
// ----------------------------------------------------------------------------
// usage
//   in channel: blk_index with in_valid / in_stall, one item per request
//   out channel: status, slot_index, evicted_block, fill_offset, fill_bytes
//     with out_valid / out_stall, one item per request, in request order
//   cfg_we / cfg_wdata write the file size in bytes; write only while idle
// an accepted item is held in the input register, then the lookup runs and
//   loads the output register, which raises out_valid; the item moves on
//   only when the output register is empty or drains
// throughput: one item per cycle while out_stall is low; the tag compare and
//   rank update over all slots resolve between input and output registers
// stall: a held output item keeps its fields; the item behind it waits in
//   the input register and in_stall rises until the output is taken
// reset (rst, synchronous): slot i holds block i at rank i, file size is
//   32769 bytes, both registers are emptied
// ----------------------------------------------------------------------------
module lru_block_window_manager_core import lbwm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [SIZE_W-1:0]     cfg_wdata,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [BLK_W-1:0]      blk_index,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic [SLOT_IDX_W-1:0] slot_index,
  output logic [BLK_W-1:0]      evicted_block,
  output logic [BLK_W-1:0]      fill_offset,
  output logic [FILL_W-1:0]     fill_bytes
);

  logic [SIZE_W-1:0] src_size;

  // input register
  logic              req_valid;
  logic [BLK_W-1:0]  req_block;

  logic              advance;
  logic              in_accept;
  lookup_t           lookup;
  fill_t             fill;

  // result fields before the output register
  status_t           status_next;
  logic [SLOT_W-1:0] slot_next;
  logic [BLK_W-1:0]  evicted_next;
  logic [BLK_W-1:0]  offset_next;
  logic [FILL_W-1:0] bytes_next;

  // the request moves on when the output register is empty or drains now
  assign advance   = req_valid && (!out_valid || !out_stall);
  assign in_stall  = req_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  // file size register
  always_ff @(posedge clk) begin
    if (rst) begin
      src_size <= SRC_SIZE_RESET;
    end else if (cfg_we) begin
      src_size <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_accept) begin
      req_valid <= 1'b1;
    end else if (advance) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_block <= blk_index;
    end
  end

  lbwm_fill_calc u_fill_calc (
    .src_size  (src_size),
    .blk_index (req_block),
    .fill      (fill)
  );

  // state only changes for an in-range request that goes out this cycle
  lbwm_tag_store u_tag_store (
    .clk        (clk),
    .rst        (rst),
    .lookup_tag (req_block),
    .update_en  (advance && fill.in_range),
    .lookup     (lookup)
  );

  // result selection, zero fields where the status has nothing to report
  always_comb begin
    status_next  = STATUS_RANGE;
    slot_next    = '0;
    evicted_next = '0;
    offset_next  = '0;
    bytes_next   = '0;
    if (fill.in_range) begin
      slot_next = lookup.slot;
      if (lookup.hit) begin
        status_next = STATUS_HIT;
      end else begin
        status_next  = STATUS_MISS;
        evicted_next = lookup.evicted;
        offset_next  = fill.offset;
        bytes_next   = fill.bytes;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status        <= status_next;
      slot_index    <= SLOT_IDX_W'(slot_next);
      evicted_block <= evicted_next;
      fill_offset   <= offset_next;
      fill_bytes    <= bytes_next;
    end
  end

endmodule
